// ===== hdl/drf_pkg.sv =====
// Shared types and constants of the distance restraint force pipeline.
package drf_pkg;

    localparam int DIMS_DEF = 3;
    localparam int IDX_W    = 12;
    localparam int POS_W    = 32;
    localparam int PRM_W    = 31;
    localparam int DIF_W    = POS_W + 1;
    localparam int SQ_W     = 2 * POS_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 33;
    localparam int QUO_W    = 17;
    localparam int P_W      = 2 * PRM_W - 16;
    localparam int IN_W     = 344;
    localparam int OUT_W    = 152;

    typedef struct packed {
        logic [IDX_W-1:0]            atom_a;
        logic [IDX_W-1:0]            atom_b;
        logic [2:0][DIF_W-1:0]       d;
        logic [PRM_W-1:0]            lo_b;
        logic [PRM_W-1:0]            up_b;
        logic [PRM_W-1:0]            mg;
        logic [PRM_W-1:0]            kk;
        logic [P_W-1:0]              p;
        logic [ROOT_W-1:0]           r;
    } t_side;

    typedef logic [2:0][QUO_W-1:0] t_quot;

endpackage

// ===== hdl/distance_restraint_force.sv =====
// Top level of the flat-bottom harmonic distance restraint force pipeline.
// One atom pair request enters per clock; the pipeline forms the difference vector
// and squared distance, then runs the bit-per-stage square root, then the three
// unit-vector dividers, and last selects the restraint piece, forms energy and
// forces and saturates them. A stall on the output holds the whole pipeline;
// nothing is dropped or repeated.
module distance_restraint_force #(
    parameter int DIMS = drf_pkg::DIMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // atom_a, atom_b, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // lower_bound, upper_bound, margin, stiffness, zero pad
    input  logic [drf_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_atom_a, out_atom_b, energy, force_x, force_y, force_z
    output logic [drf_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    logic                   w_en;
    logic [2:0][31:0]       w_pos_a, w_pos_b;
    drf_pkg::t_side         w_side_in, w_side_p, w_side_s, w_side_d;
    logic [drf_pkg::SUM_W-1:0] w_sum;
    drf_pkg::t_quot         w_quot;
    logic                   w_v_p, w_v_s, w_v_d;
    logic [11:0]            w_atom_a, w_atom_b;
    logic [31:0]            w_energy;
    logic [2:0][31:0]       w_force;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        w_pos_a[0]       = i_s_axis_tdata[55:24];
        w_pos_a[1]       = i_s_axis_tdata[87:56];
        w_pos_a[2]       = i_s_axis_tdata[119:88];
        w_pos_b[0]       = i_s_axis_tdata[151:120];
        w_pos_b[1]       = i_s_axis_tdata[183:152];
        w_pos_b[2]       = i_s_axis_tdata[215:184];
        w_side_in        = '0;
        w_side_in.atom_a = i_s_axis_tdata[11:0];
        w_side_in.atom_b = i_s_axis_tdata[23:12];
        w_side_in.lo_b   = i_s_axis_tdata[246:216];
        w_side_in.up_b   = i_s_axis_tdata[277:247];
        w_side_in.mg     = i_s_axis_tdata[308:278];
        w_side_in.kk     = i_s_axis_tdata[339:309];
    end

    drf_prep #(.DIMS(DIMS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_pos_a (w_pos_a),
        .i_pos_b (w_pos_b),
        .i_side  (w_side_in),
        .o_valid (w_v_p),
        .o_sum   (w_sum),
        .o_side  (w_side_p)
    );

    drf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v_p),
        .i_sum   (w_sum),
        .i_side  (w_side_p),
        .o_valid (w_v_s),
        .o_side  (w_side_s)
    );

    drf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v_s),
        .i_side  (w_side_s),
        .o_valid (w_v_d),
        .o_side  (w_side_d),
        .o_quot  (w_quot)
    );

    drf_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_v_d),
        .i_side   (w_side_d),
        .i_quot   (w_quot),
        .o_valid  (o_m_axis_tvalid),
        .o_atom_a (w_atom_a),
        .o_atom_b (w_atom_b),
        .o_energy (w_energy),
        .o_force  (w_force)
    );

    assign o_m_axis_tdata = {w_force[2], w_force[1], w_force[0], w_energy, w_atom_b, w_atom_a};

endmodule

// ===== hdl/drf_prep.sv =====
// Difference vector, squared components, their sum and the tail slope.
module drf_prep #(
    parameter int DIMS = drf_pkg::DIMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0][31:0]            i_pos_a,
    input  logic [2:0][31:0]            i_pos_b,
    input  drf_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [drf_pkg::SUM_W-1:0]   o_sum,
    output drf_pkg::t_side              o_side
);

    logic [2:0]                          r_v;
    drf_pkg::t_side                      r_sd1, r_sd2, r_sd3, n_sd1, n_sd2;
    logic [2*drf_pkg::PRM_W-1:0]         r_kmp;
    logic [2:0][drf_pkg::SQ_W-1:0]       r_sq;
    logic [drf_pkg::SUM_W-1:0]           r_sum;
    logic [2:0][drf_pkg::DIF_W-1:0]      n_d;
    logic [2:0][drf_pkg::DIF_W-1:0]      w_neg;
    logic [2:0][31:0]                    w_mag;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (j < DIMS) begin
                n_d[j] = {i_pos_a[j][31], i_pos_a[j]} - {i_pos_b[j][31], i_pos_b[j]};
            end else begin
                n_d[j] = '0;
            end
        end
        n_sd1   = i_side;
        n_sd1.d = n_d;
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_neg[j] = drf_pkg::DIF_W'(0) - r_sd1.d[j];
            w_mag[j] = r_sd1.d[j][drf_pkg::DIF_W-1] ? w_neg[j][31:0] : r_sd1.d[j][31:0];
        end
        n_sd2   = r_sd1;
        n_sd2.p = r_kmp[2*drf_pkg::PRM_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd1 <= n_sd1;
            r_kmp <= i_side.kk * i_side.mg;
            r_sd2 <= n_sd2;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= w_mag[j] * w_mag[j];
            end
            r_sd3 <= r_sd2;
            r_sum <= drf_pkg::SUM_W'(r_sq[0]) + drf_pkg::SUM_W'(r_sq[1])
                   + drf_pkg::SUM_W'(r_sq[2]);
        end
    end

    assign o_valid = r_v[2];
    assign o_sum   = r_sum;
    assign o_side  = r_sd3;

endmodule

// ===== hdl/drf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module drf_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [drf_pkg::SUM_W-1:0]   i_sum,
    input  drf_pkg::t_side              i_side,
    output logic                        o_valid,
    output drf_pkg::t_side              o_side
);

    localparam int NST   = drf_pkg::ROOT_W;
    localparam int REM_W = drf_pkg::SUM_W + 1;

    logic [NST-1:0]                 r_v;
    logic [REM_W-1:0]               r_rem [NST];
    logic [drf_pkg::ROOT_W-1:0]     r_res [NST];
    drf_pkg::t_side                 r_sd  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        localparam int B = NST - 1 - s;
        logic [REM_W-1:0]           w_rin, w_trial, n_rem;
        logic [drf_pkg::ROOT_W-1:0] w_qin, n_res;
        drf_pkg::t_side             w_sin;

        if (s == 0) begin : g_first
            assign w_rin = {1'b0, i_sum};
            assign w_qin = '0;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_rin = r_rem[s-1];
            assign w_qin = r_res[s-1];
            assign w_sin = r_sd[s-1];
        end

        assign w_trial = (REM_W'(w_qin) << (B + 1)) | (REM_W'(1) << (2 * B));

        always_comb begin
            if (w_rin >= w_trial) begin
                n_rem = w_rin - w_trial;
                n_res = w_qin | (drf_pkg::ROOT_W'(1) << B);
            end else begin
                n_rem = w_rin;
                n_res = w_qin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_res[s] <= n_res;
                r_sd[s]  <= w_sin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_comb begin
        o_side   = r_sd[NST-1];
        o_side.r = r_res[NST-1];
    end

    assign o_valid = r_v[NST-1];

endmodule

// ===== hdl/drf_div.sv =====
// Pipelined restoring dividers giving the unit vector, three lanes.
module drf_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  drf_pkg::t_side  i_side,
    output logic            o_valid,
    output drf_pkg::t_side  o_side,
    output drf_pkg::t_quot  o_quot
);

    localparam int NST   = drf_pkg::QUO_W;
    localparam int REM_W = 48;
    localparam int CMP_W = drf_pkg::ROOT_W + NST;

    logic [NST-1:0]         r_v;
    logic [2:0][REM_W-1:0]  r_rem [NST];
    drf_pkg::t_quot         r_q   [NST];
    drf_pkg::t_side         r_sd  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        localparam int B = NST - 1 - s;
        logic [2:0][REM_W-1:0]  w_rin, n_rem;
        drf_pkg::t_quot         w_qin, n_q;
        drf_pkg::t_side         w_sin;
        logic [CMP_W-1:0]       w_trial;
        logic [2:0][drf_pkg::DIF_W-1:0] w_neg;

        if (s == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_neg[j] = drf_pkg::DIF_W'(0) - i_side.d[j];
                    w_rin[j] = i_side.d[j][drf_pkg::DIF_W-1] ? {w_neg[j][31:0], 16'd0}
                                                             : {i_side.d[j][31:0], 16'd0};
                end
            end
            assign w_qin = '0;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_neg = '0;
            assign w_rin = r_rem[s-1];
            assign w_qin = r_q[s-1];
            assign w_sin = r_sd[s-1];
        end

        assign w_trial = CMP_W'(w_sin.r) << B;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                if (CMP_W'(w_rin[j]) >= w_trial) begin
                    n_rem[j] = w_rin[j] - w_trial[REM_W-1:0];
                    n_q[j]   = w_qin[j] | (drf_pkg::QUO_W'(1) << B);
                end else begin
                    n_rem[j] = w_rin[j];
                    n_q[j]   = w_qin[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_sd[s]  <= w_sin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_side  = r_sd[NST-1];
    assign o_quot  = r_q[NST-1];

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.r != '0) |-> (o_quot[0] <= 17'd65536 && o_quot[1] <= 17'd65536
                                         && o_quot[2] <= 17'd65536))
        else $error("unit vector component out of range");

endmodule

// ===== hdl/drf_post.sv =====
// Restraint piece selection, energy and force products, saturation.
module drf_post (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  drf_pkg::t_side          i_side,
    input  drf_pkg::t_quot          i_quot,
    output logic                    o_valid,
    output logic [11:0]             o_atom_a,
    output logic [11:0]             o_atom_b,
    output logic [31:0]             o_energy,
    output logic [2:0][31:0]        o_force
);

    localparam logic [2:0] PC_LTAIL = 3'd0;
    localparam logic [2:0] PC_LHARM = 3'd1;
    localparam logic [2:0] PC_FLAT  = 3'd2;
    localparam logic [2:0] PC_UHARM = 3'd3;
    localparam logic [2:0] PC_UTAIL = 3'd4;
    localparam int P_W = drf_pkg::P_W;

    logic [4:0]             r_v;

    // Stage 1: piece and offsets.
    logic signed [35:0]     w_r, w_l, w_u, w_m, w_h, w_lmm, w_upm;
    logic signed [35:0]     w_lt, w_ut, w_lv, w_uv;
    logic [2:0]             n_pc, r1_pc, r2_pc, r3_pc;
    logic [30:0]            n_tmag, r1_tmag;
    logic [34:0]            n_vmag, r1_vmag, r2_vmag;
    drf_pkg::t_side         r1_sd, r2_sd, r3_sd;
    drf_pkg::t_quot         r1_q, r2_q, r3_q;

    // Stage 2 to 5.
    logic [61:0]            r2_tt, r2_gk;
    logic                   w_harm;
    logic [P_W-1:0]         w_x, w_y, n_gmag, r3_gmag;
    logic                   n_gneg, r3_gneg;
    logic [68:0]            r3_elo, r3_ehi;
    logic [91:0]            w_ep, w_e;
    logic [31:0]            n_energy, r4_energy, r5_energy;
    logic [2:0][62:0]       r4_fp;
    logic [2:0]             r4_fneg;
    logic                   r4_fz;
    logic [11:0]            r4_a, r4_b, r5_a, r5_b;
    logic [2:0][46:0]       w_fm;
    logic [2:0][31:0]       n_force, r5_force;

    always_comb begin
        w_r   = 36'(i_side.r);
        w_l   = 36'(i_side.lo_b);
        w_u   = 36'(i_side.up_b);
        w_m   = 36'(i_side.mg);
        w_h   = 36'(i_side.mg[30:1]);
        w_lmm = w_l - w_m;
        w_upm = w_u + w_m;
        w_lt  = w_l - w_r;
        w_ut  = w_r - w_u;
        w_lv  = w_l - w_h - w_r;
        w_uv  = w_r - w_u - w_h;
        n_tmag = '0;
        n_vmag = '0;
        if (w_r < w_lmm) begin
            n_pc   = PC_LTAIL;
            n_vmag = w_lv[34:0];
        end else if (w_r < w_l) begin
            n_pc   = PC_LHARM;
            n_tmag = w_lt[30:0];
        end else if (w_r < w_u) begin
            n_pc   = PC_FLAT;
        end else if (w_r < w_upm) begin
            n_pc   = PC_UHARM;
            n_tmag = w_ut[30:0];
        end else begin
            n_pc   = PC_UTAIL;
            n_vmag = w_uv[34:0];
        end
    end

    always_comb begin
        w_harm = (r2_pc == PC_LHARM) || (r2_pc == PC_UHARM);
        w_x    = w_harm ? P_W'(r2_sd.kk) : r2_sd.p;
        w_y    = w_harm ? r2_tt[61:16] : P_W'(r2_vmag);
        case (r2_pc)
            PC_LTAIL: begin
                n_gmag = r2_sd.p;
                n_gneg = 1'b1;
            end
            PC_LHARM: begin
                n_gmag = r2_gk[61:16];
                n_gneg = 1'b1;
            end
            PC_UHARM: begin
                n_gmag = r2_gk[61:16];
                n_gneg = 1'b0;
            end
            PC_UTAIL: begin
                n_gmag = r2_sd.p;
                n_gneg = 1'b0;
            end
            default: begin
                n_gmag = '0;
                n_gneg = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ep = 92'(r3_elo) + (92'(r3_ehi) << 23);
        if ((r3_pc == PC_LHARM) || (r3_pc == PC_UHARM)) begin
            w_e = w_ep >> 17;
        end else begin
            w_e = w_ep >> 16;
        end
        if (r3_pc == PC_FLAT) begin
            n_energy = '0;
        end else if (|w_e[91:31]) begin
            n_energy = 32'h7FFF_FFFF;
        end else begin
            n_energy = {1'b0, w_e[30:0]};
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_fm[j] = r4_fp[j][62:16];
            if (r4_fz) begin
                n_force[j] = '0;
            end else if (r4_fneg[j]) begin
                if (|w_fm[j][46:32] || (w_fm[j][31] && |w_fm[j][30:0])) begin
                    n_force[j] = 32'h8000_0000;
                end else begin
                    n_force[j] = 32'd0 - w_fm[j][31:0];
                end
            end else if (|w_fm[j][46:31]) begin
                n_force[j] = 32'h7FFF_FFFF;
            end else begin
                n_force[j] = {1'b0, w_fm[j][30:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pc    <= n_pc;
            r1_tmag  <= n_tmag;
            r1_vmag  <= n_vmag;
            r1_sd    <= i_side;
            r1_q     <= i_quot;

            r2_tt    <= r1_tmag * r1_tmag;
            r2_gk    <= r1_sd.kk * r1_tmag;
            r2_pc    <= r1_pc;
            r2_vmag  <= r1_vmag;
            r2_sd    <= r1_sd;
            r2_q     <= r1_q;

            r3_elo   <= w_x[22:0] * w_y;
            r3_ehi   <= w_x[45:23] * w_y;
            r3_gmag  <= n_gmag;
            r3_gneg  <= n_gneg;
            r3_pc    <= r2_pc;
            r3_sd    <= r2_sd;
            r3_q     <= r2_q;

            r4_energy <= n_energy;
            for (int j = 0; j < 3; j++) begin
                r4_fp[j]   <= r3_gmag * r3_q[j];
                r4_fneg[j] <= ~(r3_gneg ^ r3_sd.d[j][drf_pkg::DIF_W-1]);
            end
            r4_fz    <= (r3_sd.r == '0);
            r4_a     <= r3_sd.atom_a;
            r4_b     <= r3_sd.atom_b;

            r5_energy <= r4_energy;
            r5_force  <= n_force;
            r5_a      <= r4_a;
            r5_b      <= r4_b;
        end
    end

    assign o_valid  = r_v[4];
    assign o_atom_a = r5_a;
    assign o_atom_b = r5_b;
    assign o_energy = r5_energy;
    assign o_force  = r5_force;

    a_energy_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_energy[31])
        else $error("restraint energy went negative");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && r3_pc == PC_FLAT && i_en) |=> (r_v[3] && r4_energy == '0))
        else $error("flat region produced energy");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && r4_fz && i_en) |=> (o_valid && o_force == '0))
        else $error("force at zero distance not cleared");

endmodule
